### sv/scta_pkg.sv
// ----------------------------------------------------------------------------
// scta_pkg: shared types, key codes and lookup tables
// Holds the set-1 key tables, the special key codes and the record types
// that pass between the translator stages.
// ----------------------------------------------------------------------------
package scta_pkg;

    localparam int unsigned KEY_W   = 7;
    localparam int unsigned CODE_W  = 8;
    localparam logic [KEY_W-1:0] KEY_COUNT = 7'd86;

    // tdata widths, whole bytes
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [CODE_W-1:0] KC_CTRL = 8'h8C;
    localparam logic [CODE_W-1:0] KC_SHFT = 8'h8D;
    localparam logic [CODE_W-1:0] KC_ALT  = 8'h8E;
    localparam logic [CODE_W-1:0] KC_CAPS = 8'h8F;
    localparam logic [CODE_W-1:0] KC_DEL  = 8'h99;

    localparam logic [CODE_W-1:0] SPECIAL_BIT = 8'h80;
    localparam logic [CODE_W-1:0] CTRL_BSLASH = 8'h1C;
    localparam logic [CODE_W-1:0] CASE_BIT    = 8'h20;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } t_mods;

    typedef struct packed {
        logic              reset_request;
        logic              key_activity;
        logic              caps_led;
        logic [CODE_W-1:0] char_code;
        logic              char_valid;
    } t_result;

    function automatic logic [CODE_W-1:0] base_code(input logic [KEY_W-1:0] key);
        logic [CODE_W-1:0] c;
        c = '0;
        case (key)
            7'd1:  c = 8'h1B;
            7'd2:  c = "1";
            7'd3:  c = "2";
            7'd4:  c = "3";
            7'd5:  c = "4";
            7'd6:  c = "5";
            7'd7:  c = "6";
            7'd8:  c = "7";
            7'd9:  c = "8";
            7'd10: c = "9";
            7'd11: c = "0";
            7'd12: c = "-";
            7'd13: c = "=";
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = "q";
            7'd17: c = "w";
            7'd18: c = "e";
            7'd19: c = "r";
            7'd20: c = "t";
            7'd21: c = "y";
            7'd22: c = "u";
            7'd23: c = "i";
            7'd24: c = "o";
            7'd25: c = "p";
            7'd26: c = "[";
            7'd27: c = "]";
            7'd28: c = 8'h0D;
            7'd29: c = KC_CTRL;
            7'd30: c = "a";
            7'd31: c = "s";
            7'd32: c = "d";
            7'd33: c = "f";
            7'd34: c = "g";
            7'd35: c = "h";
            7'd36: c = "j";
            7'd37: c = "k";
            7'd38: c = "l";
            7'd39: c = ";";
            7'd40: c = 8'h27;
            7'd41: c = 8'h60;
            7'd42: c = KC_SHFT;
            7'd43: c = 8'h5C;
            7'd44: c = "z";
            7'd45: c = "x";
            7'd46: c = "c";
            7'd47: c = "v";
            7'd48: c = "b";
            7'd49: c = "n";
            7'd50: c = "m";
            7'd51: c = ",";
            7'd52: c = ".";
            7'd53: c = "/";
            7'd54: c = KC_SHFT;
            7'd55: c = "*";
            7'd56: c = KC_ALT;
            7'd57: c = " ";
            7'd58: c = KC_CAPS;
            7'd59: c = 8'h80;
            7'd60: c = 8'h81;
            7'd61: c = 8'h82;
            7'd62: c = 8'h83;
            7'd63: c = 8'h84;
            7'd64: c = 8'h85;
            7'd65: c = 8'h86;
            7'd66: c = 8'h87;
            7'd67: c = 8'h88;
            7'd68: c = 8'h89;
            7'd71: c = 8'h90;
            7'd72: c = 8'h94;
            7'd73: c = 8'h92;
            7'd75: c = 8'h96;
            7'd77: c = 8'h97;
            7'd79: c = 8'h91;
            7'd80: c = 8'h95;
            7'd81: c = 8'h93;
            7'd82: c = 8'h98;
            7'd83: c = KC_DEL;
            7'd84: c = 8'h8A;
            7'd85: c = 8'h8B;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] shift_code(input logic [KEY_W-1:0] key);
        logic [CODE_W-1:0] c;
        c = '0;
        case (key)
            7'd1:  c = 8'h1B;
            7'd2:  c = "!";
            7'd3:  c = "@";
            7'd4:  c = "#";
            7'd5:  c = "$";
            7'd6:  c = "%";
            7'd7:  c = "^";
            7'd8:  c = "&";
            7'd9:  c = "*";
            7'd10: c = "(";
            7'd11: c = ")";
            7'd12: c = "_";
            7'd13: c = "+";
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = "Q";
            7'd17: c = "W";
            7'd18: c = "E";
            7'd19: c = "R";
            7'd20: c = "T";
            7'd21: c = "Y";
            7'd22: c = "U";
            7'd23: c = "I";
            7'd24: c = "O";
            7'd25: c = "P";
            7'd26: c = "{";
            7'd27: c = "}";
            7'd28: c = 8'h0D;
            7'd30: c = "A";
            7'd31: c = "S";
            7'd32: c = "D";
            7'd33: c = "F";
            7'd34: c = "G";
            7'd35: c = "H";
            7'd36: c = "J";
            7'd37: c = "K";
            7'd38: c = "L";
            7'd39: c = ":";
            7'd40: c = 8'h22;
            7'd41: c = "~";
            7'd43: c = "|";
            7'd44: c = "Z";
            7'd45: c = "X";
            7'd46: c = "C";
            7'd47: c = "V";
            7'd48: c = "B";
            7'd49: c = "N";
            7'd50: c = "M";
            7'd51: c = "<";
            7'd52: c = ">";
            7'd53: c = "?";
            7'd55: c = "*";
            7'd57: c = " ";
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### sv/scta_xlate.sv
// ----------------------------------------------------------------------------
// scta_xlate: scan code translation logic
// Maps one registered scan code and the current modifier flags to a result
// word and the modifier flags that follow it.
// ----------------------------------------------------------------------------
module scta_xlate (
    input  logic [scta_pkg::CODE_W-1:0] i_code,
    input  scta_pkg::t_mods             i_mods,
    output scta_pkg::t_mods             o_mods,
    output scta_pkg::t_result           o_result
);

    logic [scta_pkg::KEY_W-1:0]  key;
    logic                        press;
    logic                        in_range;
    logic [scta_pkg::CODE_W-1:0] base;
    logic [scta_pkg::CODE_W-1:0] c;
    logic                        is_mod;

    assign key      = i_code[scta_pkg::KEY_W-1:0];
    assign press    = ~i_code[scta_pkg::CODE_W-1];
    assign in_range = key < scta_pkg::KEY_COUNT;
    assign base     = scta_pkg::base_code(key);
    assign is_mod   = (base == scta_pkg::KC_SHFT) || (base == scta_pkg::KC_CTRL) ||
                      (base == scta_pkg::KC_ALT)  || (base == scta_pkg::KC_CAPS);

    // modifier flag tracking
    always_comb begin
        o_mods = i_mods;
        if (in_range) begin
            if (base == scta_pkg::KC_SHFT) begin
                o_mods.shift = press;
            end else if (base == scta_pkg::KC_CTRL) begin
                o_mods.ctrl = press;
            end else if (base == scta_pkg::KC_ALT) begin
                o_mods.alt = press;
            end else if (base == scta_pkg::KC_CAPS && press) begin
                o_mods.caps = ~i_mods.caps;
            end
        end
    end

    // character path for keys below the special range
    always_comb begin
        c = base;
        if (i_mods.ctrl) begin
            if (base >= "a" && base <= "z") begin
                c = base - 8'h60;
            end else if (base == 8'h5C) begin
                c = scta_pkg::CTRL_BSLASH;
            end else begin
                c = '0;
            end
        end else if (i_mods.shift) begin
            c = scta_pkg::shift_code(key);
        end
        if (i_mods.caps) begin
            if (c >= "A" && c <= "Z") begin
                c = c + scta_pkg::CASE_BIT;
            end else if (c >= "a" && c <= "z") begin
                c = c - scta_pkg::CASE_BIT;
            end
        end
        if (i_mods.alt && c != '0) begin
            c = c | scta_pkg::SPECIAL_BIT;
        end
    end

    always_comb begin
        o_result               = '0;
        o_result.caps_led      = o_mods.caps;
        o_result.key_activity  = in_range & press;
        if (in_range && press && !is_mod) begin
            if (base >= scta_pkg::SPECIAL_BIT) begin
                o_result.char_code     = base;
                o_result.char_valid    = 1'b1;
                o_result.reset_request = (base == scta_pkg::KC_DEL) &&
                                         i_mods.ctrl && i_mods.alt;
            end else if (c != '0) begin
                o_result.char_code  = c;
                o_result.char_valid = 1'b1;
            end
        end
    end

endmodule

### sv/scancode_to_ascii_translator_unit.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator_unit: set-1 scan code to ascii translator
// Input register, translation logic with modifier flags, result register.
// ----------------------------------------------------------------------------
// Takes set-1 scan code words and returns exactly one result word for each,
// through the input register and then the result register. A new word is
// accepted every cycle as long as the result register drains; the only loop
// is the modifier flag register, updated when a code moves from the input
// register into the result register. Result tdata carries, from bit 0 up:
// char_valid, char_code[7:0], caps_led, key_activity, reset_request, then
// zeros to bit 15.
module scancode_to_ascii_translator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [scta_pkg::S_TDATA_W-1:0] i_s_tdata,  // scan_code
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // char_valid, char_code, caps_led, key_activity, reset_request, zero pad
    output logic [scta_pkg::M_TDATA_W-1:0] o_m_tdata
);

    logic                        r_in_valid;
    logic [scta_pkg::CODE_W-1:0] r_in_code;
    logic                        r_out_valid;
    scta_pkg::t_result           r_out;
    scta_pkg::t_mods             r_mods;
    scta_pkg::t_mods             n_mods;
    scta_pkg::t_result           n_out;
    logic                        out_free;
    logic                        advance;

    assign out_free   = ~r_out_valid | i_m_tready;
    assign advance    = r_in_valid & out_free;
    assign o_s_tready = ~r_in_valid | out_free;

    scta_xlate u_xlate (
        .i_code   (r_in_code),
        .i_mods   (r_mods),
        .o_mods   (n_mods),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mods      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_mods <= n_mods;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_code <= i_s_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(scta_pkg::M_TDATA_W - $bits(scta_pkg::t_result)){1'b0}}, r_out};

endmodule

### sim/scancode_to_ascii_translator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator_unit_tb: self-checking bench for the translator
// Sends a short table of hand-picked scan codes, then modifier sequences with
// random keys and some noise, and checks every result word against the table
// answer or a behavioral model of the modifier flags and the two key maps.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator_unit_tb;

    // set-1 make codes, the release bit and the backslash code used by the bench
    localparam logic [7:0] REL_BIT   = 8'h80;
    localparam logic [7:0] SC_CTRL   = 8'h1D;
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_ALT    = 8'h38;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_DELETE = 8'h53;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 8;

    // unshifted key map, index is the key number
    localparam logic [0:85][7:0] PLAIN_MAP = {
        8'h00, 8'h1B, "1",   "2",   "3",   "4",   "5",   "6",
        "7",   "8",   "9",   "0",   "-",   "=",   8'h08, 8'h09,
        "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
        "o",   "p",   "[",   "]",   8'h0D, scta_pkg::KC_CTRL, "a", "s",
        "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
        8'h27, 8'h60, scta_pkg::KC_SHFT, 8'h5C, "z", "x",   "c",   "v",
        "b",   "n",   "m",   ",",   ".",   "/",   scta_pkg::KC_SHFT, "*",
        scta_pkg::KC_ALT, " ",  scta_pkg::KC_CAPS, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h90,
        8'h94, 8'h92, 8'h00, 8'h96, 8'h00, 8'h97, 8'h00, 8'h91,
        8'h95, 8'h93, 8'h98, scta_pkg::KC_DEL, 8'h8A, 8'h8B
    };

    // map used while shift is held
    localparam logic [0:85][7:0] UPPER_MAP = {
        8'h00, 8'h1B, "!",   "@",   "#",   "$",   "%",   "^",
        "&",   "*",   "(",   ")",   "_",   "+",   8'h08, 8'h09,
        "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
        "O",   "P",   "{",   "}",   8'h0D, 8'h00, "A",   "S",
        "D",   "F",   "G",   "H",   "J",   "K",   "L",   ":",
        8'h22, "~",   8'h00, "|",   "Z",   "X",   "C",   "V",
        "B",   "N",   "M",   "<",   ">",   "?",   8'h00, "*",
        8'h00, " ",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        {22{8'h00}}
    };

    typedef struct packed {
        logic              typed;
        scta_pkg::t_result want;
        logic [7:0]        scan;
    } t_dir_row;

    localparam int unsigned DIR_N = 26;

    // columns: typed, reset_request, key_activity, caps_led, char_code,
    // char_valid, scan code; rows with typed low take the model's answer
    localparam t_dir_row [0:DIR_N-1] DIR_TABLE = {
        {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00},          // empty key 0
        {1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF},          // out of range
        {1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h56},          // first unused key
        {1'b1, 1'b0, 1'b1, 1'b0, 8'h61, 1'b1, 8'h1E},          // plain a
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h9E},          // release a
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_LSHIFT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h1E},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h02},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_CAPS},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h1E},          // shift and caps
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_CAPS | REL_BIT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_LSHIFT | REL_BIT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h10},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_CTRL},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h2B},          // ctrl backslash
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h1C},          // ctrl drops enter
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_ALT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h1E},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_DELETE},      // ctrl alt del
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_CTRL | REL_BIT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h02},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_ALT | REL_BIT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_RSHIFT},
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h55},          // last key, special
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h45},          // empty map entry
        {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, SC_RSHIFT | REL_BIT}
    };

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [scta_pkg::S_TDATA_W-1:0]  i_s_tdata  = '0;   // scan_code
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // char_valid, char_code, caps_led, key_activity, reset_request, zero pad
    logic [scta_pkg::M_TDATA_W-1:0]  o_m_tdata;

    logic [7:0]        scan_stim[$];
    bit                typed_stim[$];
    scta_pkg::t_result typed_want[$];
    scta_pkg::t_result key_results_q[$];
    scta_pkg::t_mods   kbd_mods;
    int unsigned       keys_in_range;
    int unsigned       scans_taken;
    int unsigned       mismatch_cnt;

    scancode_to_ascii_translator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic scta_pkg::t_result translate_scan(input logic [7:0] scan);
        scta_pkg::t_result res;
        logic [6:0]        key;
        logic              pressed;
        logic [7:0]        plain;
        logic [7:0]        ch;
        res     = '0;
        key     = scan[6:0];
        pressed = ~scan[7];
        if (key < scta_pkg::KEY_COUNT) begin
            plain            = PLAIN_MAP[key];
            res.key_activity = pressed;
            if (plain == scta_pkg::KC_SHFT) begin
                kbd_mods.shift = pressed;
            end else if (plain == scta_pkg::KC_CTRL) begin
                kbd_mods.ctrl = pressed;
            end else if (plain == scta_pkg::KC_ALT) begin
                kbd_mods.alt = pressed;
            end else if (plain == scta_pkg::KC_CAPS) begin
                if (pressed) kbd_mods.caps = ~kbd_mods.caps;
            end else if (pressed) begin
                if (plain >= scta_pkg::SPECIAL_BIT) begin
                    // special keys ignore every modifier in their char code
                    res.reset_request = (plain == scta_pkg::KC_DEL) && kbd_mods.ctrl &&
                                        kbd_mods.alt;
                    res.char_code     = plain;
                    res.char_valid    = 1'b1;
                end else begin
                    ch = plain;
                    if (kbd_mods.ctrl) begin
                        if (ch >= "a" && ch <= "z") ch = ch - "a" + 8'd1;
                        else if (ch == CH_BSLASH) ch = scta_pkg::CTRL_BSLASH;
                        else ch = 8'h00;
                    end else if (kbd_mods.shift) begin
                        ch = UPPER_MAP[key];
                    end
                    if (ch != 8'h00) begin
                        if (kbd_mods.caps) begin
                            if (ch >= "A" && ch <= "Z") ch = ch + scta_pkg::CASE_BIT;
                            else if (ch >= "a" && ch <= "z") ch = ch - scta_pkg::CASE_BIT;
                        end
                        if (kbd_mods.alt) ch = ch | scta_pkg::SPECIAL_BIT;
                        res.char_code  = ch;
                        res.char_valid = 1'b1;
                    end
                end
            end
        end
        res.caps_led = kbd_mods.caps;
        return res;
    endfunction

    task automatic add_scan(input logic [7:0] scan, input bit typed,
                            input scta_pkg::t_result want);
        scan_stim.push_back(scan);
        typed_stim.push_back(typed);
        typed_want.push_back(want);
        // codes the block ignores do not count toward the random quota
        if (scan[6:0] < scta_pkg::KEY_COUNT) keys_in_range++;
    endtask

    task automatic check_result(input scta_pkg::t_result want, input scta_pkg::t_result got);
        if (got.char_valid !== want.char_valid) begin
            $error("char_valid: expected %0d, got %0d", want.char_valid, got.char_valid);
            mismatch_cnt++;
        end
        if (got.char_code !== want.char_code) begin
            $error("char_code: expected %02h, got %02h", want.char_code, got.char_code);
            mismatch_cnt++;
        end
        if (got.caps_led !== want.caps_led) begin
            $error("caps_led: expected %0d, got %0d", want.caps_led, got.caps_led);
            mismatch_cnt++;
        end
        if (got.key_activity !== want.key_activity) begin
            $error("key_activity: expected %0d, got %0d", want.key_activity,
                   got.key_activity);
            mismatch_cnt++;
        end
        if (got.reset_request !== want.reset_request) begin
            $error("reset_request: expected %0d, got %0d", want.reset_request,
                   got.reset_request);
            mismatch_cnt++;
        end
    endtask

    // both handshakes sampled at the edge, before any driven value moves
    always @(posedge i_clk) begin
        scta_pkg::t_result predicted;
        scta_pkg::t_result got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predicted = translate_scan(i_s_tdata);
                key_results_q.push_back(typed_stim[scans_taken] ? typed_want[scans_taken]
                                                                : predicted);
                scans_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[$bits(scta_pkg::t_result)-1:0];
                if (key_results_q.size() == 0) begin
                    $error("result word with no expectation: %04h", o_m_tdata);
                    mismatch_cnt++;
                end else begin
                    check_result(key_results_q.pop_front(), got);
                end
            end
        end
    end

    initial begin : source
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        int unsigned guard;
        int unsigned pause_idx;
        int unsigned n_keys;
        bit          use_shift;
        bit          use_ctrl;
        bit          use_alt;
        logic [7:0]  shift_key;
        logic [7:0]  key;
        kbd_mods      = '0;
        keys_in_range = 0;
        scans_taken   = 0;
        mismatch_cnt  = 0;

        for (idx = 0; idx < DIR_N; idx++) begin
            add_scan(DIR_TABLE[idx].scan, DIR_TABLE[idx].typed, DIR_TABLE[idx].want);
        end

        while (keys_in_range < DIR_N + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_scan(8'($urandom_range(0, 255)), 1'b0, '0);
                end
                1: begin
                    // stray release or a modifier left hanging
                    if ($urandom_range(0, 1)) begin
                        add_scan(REL_BIT | 8'($urandom_range(0, 85)), 1'b0, '0);
                    end else begin
                        case ($urandom_range(0, 2))
                            0: add_scan(SC_CTRL, 1'b0, '0);
                            1: add_scan(SC_ALT, 1'b0, '0);
                            default: add_scan(SC_RSHIFT, 1'b0, '0);
                        endcase
                    end
                end
                default: begin
                    use_shift = 1'($urandom_range(0, 1));
                    use_ctrl  = ($urandom_range(0, 2) == 0);
                    use_alt   = ($urandom_range(0, 2) == 0);
                    shift_key = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
                    if ($urandom_range(0, 7) == 0) begin
                        add_scan(SC_CAPS, 1'b0, '0);
                        add_scan(SC_CAPS | REL_BIT, 1'b0, '0);
                    end
                    if (use_ctrl) add_scan(SC_CTRL, 1'b0, '0);
                    if (use_alt) add_scan(SC_ALT, 1'b0, '0);
                    if (use_shift) add_scan(shift_key, 1'b0, '0);
                    n_keys = $urandom_range(1, 4);
                    repeat (n_keys) begin
                        key = ($urandom_range(0, 7) == 0) ? SC_DELETE
                                                          : 8'($urandom_range(0, 85));
                        add_scan(key, 1'b0, '0);
                        if ($urandom_range(0, 1)) add_scan(key | REL_BIT, 1'b0, '0);
                    end
                    if (use_shift) add_scan(shift_key | REL_BIT, 1'b0, '0);
                    if (use_alt) add_scan(SC_ALT | REL_BIT, 1'b0, '0);
                    if (use_ctrl) add_scan(SC_CTRL | REL_BIT, 1'b0, '0);
                end
            endcase
        end
        pause_idx = scan_stim.size() / 2;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < scan_stim.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            while (burst != 0 && idx < scan_stim.size()) begin
                if (idx == DIR_N || idx == pause_idx) begin
                    // let the block run dry before going on
                    i_s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (key_results_q.size() != 0) @(posedge i_clk);
                end
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= scan_stim[idx];
                @(posedge i_clk);
                while (!o_s_tready) @(posedge i_clk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0 && idx < scan_stim.size()) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        guard = 0;
        while (key_results_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (key_results_q.size() != 0) begin
            $error("%0d expected result words never arrived", key_results_q.size());
            mismatch_cnt++;
        end

        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // sink: changes its stall pattern as bits 8:7 of its cycle counter step, with one long hold-off
    initial begin : sink
        int unsigned cyc;
        int unsigned hold_left;
        bit          hold_done;
        cyc       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!hold_done && scans_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (cyc[8:7])
                    2'd0: i_m_tready <= 1'b1;
                    2'd1: i_m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: i_m_tready <= cyc[1];
                    default: i_m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
sv/scta_pkg.sv
sv/scta_xlate.sv
sv/scancode_to_ascii_translator_unit.sv
sim/scancode_to_ascii_translator_unit_tb.sv
